// ----- hdl/mvdr_pkg.sv -----
// shared types and constants for the mesh vertex delete and remap block
// no dependencies

package mvdr_pkg;

   // default sizes of the vertex and triangle spaces
   localparam int MAX_VERTS_DEF = 4096;
   localparam int MAX_TRIS_DEF  = 65536;

   // field widths
   localparam int CMD_W = 3;
   localparam int IDX_W = 13;
   localparam int ST_W  = 2;
   localparam int OUT_W = 17;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic CSR_VERTEX_COUNT = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      CMD_START    = 3'd0,
      CMD_DELETE   = 3'd1,
      CMD_RENUMBER = 3'd2,
      CMD_TRIANGLE = 3'd3,
      CMD_LOOKUP   = 3'd4
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_ORDER = 2'd2
   } status_type;

   typedef enum logic {
      PH_MARK  = 1'b0,
      PH_REMAP = 1'b1
   } phase_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RENUM,
      S_TRI_B,
      S_TRI_C,
      S_TRI_D,
      S_LOOK
   } state_type;

endpackage

// ----- hdl/mvdr_ram.sv -----
// simple dual port synchronous ram, one write and one registered read port
// no dependencies

module mvdr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/mvdr_csr.sv -----
// apb-style register file holding the vertex count
// depends on mvdr_pkg

module mvdr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mvdr_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [mvdr_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [mvdr_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                                csr_pready,
   output logic [mvdr_pkg::IDX_W-1:0]          vertex_count
);

   logic [mvdr_pkg::IDX_W-1:0] vcount_ff;
   logic [mvdr_pkg::IDX_W-1:0] vcount_in;
   logic                       wr_hit;

   // register index is the word address
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == mvdr_pkg::CSR_VERTEX_COUNT);

   always_comb begin
      vcount_in = vcount_ff;
      if (wr_hit) begin
         vcount_in = csr_pwdata[mvdr_pkg::IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
      end else begin
         vcount_ff <= vcount_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == mvdr_pkg::CSR_VERTEX_COUNT) begin
         csr_prdata = mvdr_pkg::CSR_DW'(vcount_ff);
      end
   end

   assign csr_pready   = 1'b1;
   assign vertex_count = vcount_ff;

endmodule

// ----- hdl/mesh_vertex_delete_remap.sv -----
// top level: command sequencer for vertex deletion, renumbering and triangle remap
// depends on mvdr_pkg, mvdr_ram, mvdr_csr
//
//  channel   ports                          handshake
//  ------    -----------------------------  ------------------------------------
//  command   start, busy, req_*             taken at an edge with start & !busy
//  result    rsp_valid, rsp_*               one cycle strobe, cannot be held off
//  csr       csr_psel ... csr_pready        apb write in setup + access, no wait
//
//  delete and out-of-order or out-of-range items answer in the next cycle;
//  lookup via S_LOOK, triangle via S_TRI_B, S_TRI_C and S_TRI_D (three reads
//  through the single remap ram read port); start answers at once, then sweeps
//  the keep flags; renumber walks every vertex under busy and answers at the end
//  after reset a clearing pass sets every keep flag; busy is high
//  busy is the only back pressure; results are never stalled

module mesh_vertex_delete_remap #(
   parameter int MAX_VERTS = mvdr_pkg::MAX_VERTS_DEF,
   parameter int MAX_TRIS  = mvdr_pkg::MAX_TRIS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              start,
   output logic                              busy,
   input  logic [mvdr_pkg::CMD_W-1:0]        req_command,
   input  logic [mvdr_pkg::IDX_W-1:0]        req_vertex_index,
   input  logic [mvdr_pkg::IDX_W-1:0]        req_corner_a,
   input  logic [mvdr_pkg::IDX_W-1:0]        req_corner_b,
   input  logic [mvdr_pkg::IDX_W-1:0]        req_corner_c,
   // result channel
   output logic                              rsp_valid,
   output logic [mvdr_pkg::ST_W-1:0]         rsp_status,
   output logic                              rsp_kept,
   output logic [mvdr_pkg::OUT_W-1:0]        rsp_new_id,
   output logic [mvdr_pkg::IDX_W-1:0]        rsp_new_a,
   output logic [mvdr_pkg::IDX_W-1:0]        rsp_new_b,
   output logic [mvdr_pkg::IDX_W-1:0]        rsp_new_c,
   output logic [mvdr_pkg::OUT_W-1:0]        rsp_total,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mvdr_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [mvdr_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [mvdr_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                              csr_pready
);

   localparam int IDX_W = mvdr_pkg::IDX_W;
   localparam int OUT_W = mvdr_pkg::OUT_W;
   // vertex address, walk counter and triangle counter widths
   localparam int AW = $clog2(MAX_VERTS);
   localparam int TW = $clog2(MAX_TRIS + 1);
   // common widths for compares and truncation
   localparam int XW = (AW > IDX_W) ? AW : IDX_W;
   localparam int CW = ((AW + 1) > IDX_W) ? (AW + 1) : IDX_W;
   localparam int KW = (TW > OUT_W) ? TW : OUT_W;
   localparam logic [CW-1:0] MAXV_C    = CW'(MAX_VERTS);
   localparam logic [AW:0]   WALK_END  = (AW + 1)'(MAX_VERTS);
   localparam logic [AW:0]   WALK_LAST = (AW + 1)'(MAX_VERTS - 1);
   localparam logic [TW-1:0] TRI_FULL  = TW'(MAX_TRIS);

   // configuration
   logic [IDX_W-1:0] vertex_count;

   // sequencer state
   mvdr_pkg::state_type  state_ff, state_in;
   mvdr_pkg::phase_type  phase_ff, phase_in;
   logic [AW:0]          walk_ff, walk_in;
   logic                 pend_ff, pend_in;          // keep flag read in flight
   logic [AW-1:0]        pend_addr_ff, pend_addr_in;
   logic                 pend_live_ff, pend_live_in; // vertex below the count
   logic [IDX_W-1:0]     kept_v_ff, kept_v_in;
   logic [TW-1:0]        kept_t_ff, kept_t_in;
   logic [AW-1:0]        corner_b_ff, corner_b_in;
   logic [AW-1:0]        corner_c_ff, corner_c_in;
   logic [IDX_W-1:0]     ra_ff, ra_in;
   logic [IDX_W-1:0]     rb_ff, rb_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   mvdr_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic                    rsp_kept_ff, rsp_kept_in;
   logic [OUT_W-1:0]        rsp_new_id_ff, rsp_new_id_in;
   logic [IDX_W-1:0]        rsp_new_a_ff, rsp_new_a_in;
   logic [IDX_W-1:0]        rsp_new_b_ff, rsp_new_b_in;
   logic [IDX_W-1:0]        rsp_new_c_ff, rsp_new_c_in;
   logic [OUT_W-1:0]        rsp_total_ff, rsp_total_in;

   // ram ports
   logic             keep_we, keep_wdata, keep_rdata;
   logic [AW-1:0]    keep_waddr, keep_raddr;
   logic             store_we;
   logic [AW-1:0]    store_waddr, store_raddr;
   logic [IDX_W-1:0] store_wdata, store_rdata;

   // decoded command
   logic                 accept;
   mvdr_pkg::cmd_type    cmd;
   logic                 vi_ok, a_ok, b_ok, c_ok;
   logic [KW-1:0]        kt_cur_ext, kt_inc_ext;
   logic [TW-1:0]        kt_inc;

   // 1-based index inside 1..min(vertex_count, MAX_VERTS)
   function automatic logic in_rng(input logic [IDX_W-1:0] v, input logic [IDX_W-1:0] n);
      logic [CW-1:0] ve;
      ve = CW'(v);
      return (v != '0) && (v <= n) && (ve <= MAXV_C);
   endfunction

   // 1-based index to ram address
   function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] v);
      logic [XW-1:0] e;
      e = XW'(v) - XW'(1);
      return e[AW-1:0];
   endfunction

   mvdr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .vertex_count (vertex_count)
   );

   // one flag per vertex, 1 = kept
   mvdr_ram #(.WIDTH(1), .DEPTH(MAX_VERTS)) u_keep_ram (
      .clock (clock),
      .we    (keep_we),
      .waddr (keep_waddr),
      .wdata (keep_wdata),
      .raddr (keep_raddr),
      .rdata (keep_rdata)
   );

   // new dense index per vertex, 0 = removed
   mvdr_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTS)) u_remap_ram (
      .clock (clock),
      .we    (store_we),
      .waddr (store_waddr),
      .wdata (store_wdata),
      .raddr (store_raddr),
      .rdata (store_rdata)
   );

   assign busy   = (state_ff != mvdr_pkg::S_IDLE);
   assign accept = start && !busy;
   assign cmd    = mvdr_pkg::cmd_type'(req_command);
   assign vi_ok  = in_rng(req_vertex_index, vertex_count);
   assign a_ok   = in_rng(req_corner_a, vertex_count);
   assign b_ok   = in_rng(req_corner_b, vertex_count);
   assign c_ok   = in_rng(req_corner_c, vertex_count);

   // triangle count as seen on the 17-bit result fields
   assign kt_inc     = kept_t_ff + TW'(1);
   assign kt_cur_ext = KW'(kept_t_ff);
   assign kt_inc_ext = KW'(kt_inc);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mvdr_pkg::S_CLEAR: begin
            if (walk_ff == WALK_LAST) begin
               state_in = mvdr_pkg::S_IDLE;
            end
         end
         mvdr_pkg::S_IDLE: begin
            if (accept) begin
               case (cmd)
                  mvdr_pkg::CMD_START: begin
                     state_in = mvdr_pkg::S_CLEAR;
                  end
                  mvdr_pkg::CMD_RENUMBER: begin
                     if (phase_ff == mvdr_pkg::PH_MARK) begin
                        state_in = mvdr_pkg::S_RENUM;
                     end
                  end
                  mvdr_pkg::CMD_TRIANGLE: begin
                     if (phase_ff == mvdr_pkg::PH_REMAP && a_ok && b_ok && c_ok) begin
                        state_in = mvdr_pkg::S_TRI_B;
                     end
                  end
                  mvdr_pkg::CMD_LOOKUP: begin
                     if (phase_ff == mvdr_pkg::PH_REMAP && vi_ok) begin
                        state_in = mvdr_pkg::S_LOOK;
                     end
                  end
                  default: begin
                     state_in = mvdr_pkg::S_IDLE;
                  end
               endcase
            end
         end
         mvdr_pkg::S_RENUM: begin
            if (walk_ff == WALK_END && !pend_ff) begin
               state_in = mvdr_pkg::S_IDLE;
            end
         end
         mvdr_pkg::S_TRI_B: state_in = mvdr_pkg::S_TRI_C;
         mvdr_pkg::S_TRI_C: state_in = mvdr_pkg::S_TRI_D;
         mvdr_pkg::S_TRI_D: state_in = mvdr_pkg::S_IDLE;
         mvdr_pkg::S_LOOK:  state_in = mvdr_pkg::S_IDLE;
         default:           state_in = mvdr_pkg::S_IDLE;
      endcase
   end

   // datapath, ram ports and result
   always_comb begin
      walk_in       = walk_ff;
      phase_in      = phase_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pend_live_in  = pend_live_ff;
      kept_v_in     = kept_v_ff;
      kept_t_in     = kept_t_ff;
      corner_b_in   = corner_b_ff;
      corner_c_in   = corner_c_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;

      keep_we       = 1'b0;
      keep_waddr    = '0;
      keep_wdata    = 1'b0;
      keep_raddr    = '0;
      store_we      = 1'b0;
      store_waddr   = '0;
      store_wdata   = '0;
      store_raddr   = '0;

      rsp_valid_in  = 1'b0;
      rsp_status_in = mvdr_pkg::ST_OK;
      rsp_kept_in   = 1'b0;
      rsp_new_id_in = '0;
      rsp_new_a_in  = '0;
      rsp_new_b_in  = '0;
      rsp_new_c_in  = '0;
      rsp_total_in  = kt_cur_ext[OUT_W-1:0];

      case (state_ff)
         mvdr_pkg::S_CLEAR: begin
            // mark every vertex kept, one entry a cycle
            keep_we    = 1'b1;
            keep_waddr = walk_ff[AW-1:0];
            keep_wdata = 1'b1;
            walk_in    = walk_ff + (AW + 1)'(1);
         end
         mvdr_pkg::S_IDLE: begin
            if (accept) begin
               case (cmd)
                  mvdr_pkg::CMD_START: begin
                     walk_in      = '0;
                     kept_v_in    = '0;
                     kept_t_in    = '0;
                     phase_in     = mvdr_pkg::PH_MARK;
                     rsp_valid_in = 1'b1;
                     rsp_total_in = '0;
                  end
                  mvdr_pkg::CMD_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (phase_ff != mvdr_pkg::PH_MARK) begin
                        rsp_status_in = mvdr_pkg::ST_ORDER;
                     end else if (!vi_ok) begin
                        rsp_status_in = mvdr_pkg::ST_RANGE;
                     end else begin
                        keep_we    = 1'b1;
                        keep_waddr = to_addr(req_vertex_index);
                        keep_wdata = 1'b0;
                     end
                  end
                  mvdr_pkg::CMD_RENUMBER: begin
                     if (phase_ff != mvdr_pkg::PH_MARK) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = mvdr_pkg::ST_ORDER;
                        rsp_total_in  = OUT_W'(kept_v_ff);
                     end else begin
                        walk_in   = '0;
                        kept_v_in = '0;
                     end
                  end
                  mvdr_pkg::CMD_TRIANGLE: begin
                     if (phase_ff != mvdr_pkg::PH_REMAP) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = mvdr_pkg::ST_ORDER;
                     end else if (!(a_ok && b_ok && c_ok)) begin
                        // dropped, no id used
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = mvdr_pkg::ST_RANGE;
                     end else begin
                        store_raddr = to_addr(req_corner_a);
                        corner_b_in = to_addr(req_corner_b);
                        corner_c_in = to_addr(req_corner_c);
                     end
                  end
                  mvdr_pkg::CMD_LOOKUP: begin
                     if (phase_ff != mvdr_pkg::PH_REMAP) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = mvdr_pkg::ST_ORDER;
                     end else if (!vi_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = mvdr_pkg::ST_RANGE;
                     end else begin
                        store_raddr = to_addr(req_vertex_index);
                     end
                  end
                  default: begin
                     // unknown command
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = mvdr_pkg::ST_ORDER;
                  end
               endcase
            end
         end
         mvdr_pkg::S_RENUM: begin
            // issue keep flag reads over every entry
            if (walk_ff != WALK_END) begin
               keep_raddr   = walk_ff[AW-1:0];
               walk_in      = walk_ff + (AW + 1)'(1);
               pend_in      = 1'b1;
               pend_addr_in = walk_ff[AW-1:0];
               pend_live_in = CW'(walk_ff) < CW'(vertex_count);
            end
            // flag back from the ram: write the dense index, 0 for removed or beyond the count
            if (pend_ff) begin
               store_we    = 1'b1;
               store_waddr = pend_addr_ff;
               if (pend_live_ff && keep_rdata) begin
                  kept_v_in   = kept_v_ff + IDX_W'(1);
                  store_wdata = kept_v_ff + IDX_W'(1);
               end
            end
            if (walk_ff == WALK_END && !pend_ff) begin
               phase_in     = mvdr_pkg::PH_REMAP;
               rsp_valid_in = 1'b1;
               rsp_total_in = OUT_W'(kept_v_ff);
            end
         end
         mvdr_pkg::S_TRI_B: begin
            ra_in       = store_rdata;
            store_raddr = corner_b_ff;
         end
         mvdr_pkg::S_TRI_C: begin
            rb_in       = store_rdata;
            store_raddr = corner_c_ff;
         end
         mvdr_pkg::S_TRI_D: begin
            rsp_valid_in = 1'b1;
            if (ra_ff != '0 && rb_ff != '0 && store_rdata != '0) begin
               if (kept_t_ff == TRI_FULL) begin
                  // id space exhausted
                  rsp_status_in = mvdr_pkg::ST_RANGE;
               end else begin
                  kept_t_in     = kt_inc;
                  rsp_kept_in   = 1'b1;
                  rsp_new_id_in = kt_inc_ext[OUT_W-1:0];
                  rsp_new_a_in  = ra_ff;
                  rsp_new_b_in  = rb_ff;
                  rsp_new_c_in  = store_rdata;
                  rsp_total_in  = kt_inc_ext[OUT_W-1:0];
               end
            end
         end
         mvdr_pkg::S_LOOK: begin
            rsp_valid_in  = 1'b1;
            rsp_new_id_in = OUT_W'(store_rdata);
            rsp_kept_in   = (store_rdata != '0);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mvdr_pkg::S_CLEAR;
         phase_ff     <= mvdr_pkg::PH_MARK;
         walk_ff      <= '0;
         pend_ff      <= 1'b0;
         kept_v_ff    <= '0;
         kept_t_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         walk_ff      <= walk_in;
         pend_ff      <= pend_in;
         kept_v_ff    <= kept_v_in;
         kept_t_ff    <= kept_t_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_addr_ff  <= pend_addr_in;
      pend_live_ff  <= pend_live_in;
      corner_b_ff   <= corner_b_in;
      corner_c_ff   <= corner_c_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      rsp_status_ff <= rsp_status_in;
      rsp_kept_ff   <= rsp_kept_in;
      rsp_new_id_ff <= rsp_new_id_in;
      rsp_new_a_ff  <= rsp_new_a_in;
      rsp_new_b_ff  <= rsp_new_b_in;
      rsp_new_c_ff  <= rsp_new_c_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_kept   = rsp_kept_ff;
   assign rsp_new_id = rsp_new_id_ff;
   assign rsp_new_a  = rsp_new_a_ff;
   assign rsp_new_b  = rsp_new_b_ff;
   assign rsp_new_c  = rsp_new_c_ff;
   assign rsp_total  = rsp_total_ff;

   // leaving reset always starts the keep flag clearing pass
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> (state_ff == mvdr_pkg::S_CLEAR && walk_ff == '0))
      else $error("clearing pass not started after reset");

   // the remap ram is only written by the renumber walk
   a_store_write_in_renum: assert property (@(posedge clock) disable iff (reset)
      store_we |-> (state_ff == mvdr_pkg::S_RENUM && pend_ff))
      else $error("remap ram written outside renumber");

   // a triangle gives no result while its corners are still being read
   a_tri_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mvdr_pkg::S_TRI_B) |=> (state_ff == mvdr_pkg::S_TRI_C && !rsp_valid_ff))
      else $error("triangle result before all corners read");

   // triangle count never passes the id space
   a_tri_count_bound: assert property (@(posedge clock) disable iff (reset)
      kept_t_ff <= TRI_FULL)
      else $error("triangle count beyond limit");

   // no new item is taken while the renumber walk is in flight
   a_busy_while_walking: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mvdr_pkg::S_RENUM && walk_ff != WALK_END) |=> busy)
      else $error("renumber walk ended early");

endmodule

// ----- tb/mesh_vertex_delete_remap_test.sv -----
// testbench for mesh_vertex_delete_remap: directed table, then random rounds
// depends on mvdr_pkg and the block's rtl; results checked against an in-bench predictor

module mesh_vertex_delete_remap_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CMD_W         = mvdr_pkg::CMD_W;
   localparam int IDX_W         = mvdr_pkg::IDX_W;
   localparam int ST_W          = mvdr_pkg::ST_W;
   localparam int OUT_W         = mvdr_pkg::OUT_W;
   localparam int CSR_AW        = mvdr_pkg::CSR_AW;
   localparam int CSR_DW        = mvdr_pkg::CSR_DW;
   localparam int MAX_VERTS_DEF = mvdr_pkg::MAX_VERTS_DEF;
   localparam int MAX_TRIS_DEF  = mvdr_pkg::MAX_TRIS_DEF;

   localparam int CLK_PERIOD     = 10;
   localparam int RANDOM_ITEMS   = 1100;
   localparam int WATCHDOG_LIMIT = 20000;  // longer than the renumber walk and the start sweep
   localparam int TAIL_CYCLES    = 100;
   localparam int MAX_REPORTS    = 40;
   localparam int WINDOW         = 24;     // vertices touched by one random round

   // command codes the block does not know
   localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   localparam logic [CSR_AW-1:0] VERTEX_COUNT_ADDR =
      CSR_AW'(4 * mvdr_pkg::CSR_VERTEX_COUNT);

   typedef struct packed {
      mvdr_pkg::status_type   status;
      logic                   kept;
      logic [OUT_W-1:0]       new_id;
      logic [IDX_W-1:0]       new_a;
      logic [IDX_W-1:0]       new_b;
      logic [IDX_W-1:0]       new_c;
      logic [OUT_W-1:0]       total;
   } remap_result_type;

   // one row of the directed table: either a vertex count write (value in vi) or an item
   typedef struct packed {
      bit                     csr_write;
      logic [CMD_W-1:0]       cmd;
      logic [IDX_W-1:0]       vi;
      logic [IDX_W-1:0]       ca;
      logic [IDX_W-1:0]       cb;
      logic [IDX_W-1:0]       cc;
      bit                     typed;
      mvdr_pkg::status_type   exp_status;
      logic [OUT_W-1:0]       exp_total;
   } directed_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_command = '0;
   logic [IDX_W-1:0]    req_vertex_index = '0;
   logic [IDX_W-1:0]    req_corner_a = '0;
   logic [IDX_W-1:0]    req_corner_b = '0;
   logic [IDX_W-1:0]    req_corner_c = '0;
   logic                rsp_valid;
   logic [ST_W-1:0]     rsp_status;
   logic                rsp_kept;
   logic [OUT_W-1:0]    rsp_new_id;
   logic [IDX_W-1:0]    rsp_new_a;
   logic [IDX_W-1:0]    rsp_new_b;
   logic [IDX_W-1:0]    rsp_new_c;
   logic [OUT_W-1:0]    rsp_total;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   mesh_vertex_delete_remap dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_vertex_index (req_vertex_index),
      .req_corner_a     (req_corner_a),
      .req_corner_b     (req_corner_b),
      .req_corner_c     (req_corner_c),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_kept         (rsp_kept),
      .rsp_new_id       (rsp_new_id),
      .rsp_new_a        (rsp_new_a),
      .rsp_new_b        (rsp_new_b),
      .rsp_new_c        (rsp_new_c),
      .rsp_total        (rsp_total),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // predictor state, mirrors the block's mesh bookkeeping
   bit                  keep_flag [MAX_VERTS_DEF] = '{default: 1'b1};
   logic [IDX_W-1:0]    new_index [MAX_VERTS_DEF] = '{default: '0};
   int                  kept_vertex_total = 0;
   int                  kept_tri_total = 0;
   mvdr_pkg::phase_type remap_phase = mvdr_pkg::PH_MARK;
   int                  vertex_count_cfg = 0;

   remap_result_type    pending_results [$];
   int                  mismatch_count = 0;
   int                  result_count = 0;
   int                  quiet_cycles = 0;

   // directed table: some errors and easy cases carry a typed expectation, the rest go to the predictor
   directed_row_type directed_rows [28] = '{
      '{1'b1, mvdr_pkg::CMD_START, 13'd4, '0, '0, '0, 1'b0, mvdr_pkg::ST_OK, '0},
      // marking phase: remap-only commands and unknown codes are out of order
      '{1'b0, mvdr_pkg::CMD_LOOKUP, 13'd1, '0, '0, '0, 1'b1, mvdr_pkg::ST_ORDER, '0},
      '{1'b0, mvdr_pkg::CMD_TRIANGLE, '0, 13'd1, 13'd2, 13'd3, 1'b1, mvdr_pkg::ST_ORDER, '0},
      '{1'b0, CMD_SPARE_5, '0, '0, '0, '0, 1'b1, mvdr_pkg::ST_ORDER, '0},
      '{1'b0, CMD_SPARE_7, 13'd8191, 13'd8191, 13'd8191, 13'd8191,
        1'b1, mvdr_pkg::ST_ORDER, '0},
      '{1'b0, mvdr_pkg::CMD_START, '0, '0, '0, '0, 1'b1, mvdr_pkg::ST_OK, '0},
      // delete: zero, one past the count, all ones, then a good one
      '{1'b0, mvdr_pkg::CMD_DELETE, '0, '0, '0, '0, 1'b1, mvdr_pkg::ST_RANGE, '0},
      '{1'b0, mvdr_pkg::CMD_DELETE, 13'd5, '0, '0, '0, 1'b1, mvdr_pkg::ST_RANGE, '0},
      '{1'b0, mvdr_pkg::CMD_DELETE, 13'd8191, '0, '0, '0, 1'b1, mvdr_pkg::ST_RANGE, '0},
      '{1'b0, mvdr_pkg::CMD_DELETE, 13'd2, '0, '0, '0, 1'b1, mvdr_pkg::ST_OK, '0},
      // renumber, then a second one out of order
      '{1'b0, mvdr_pkg::CMD_RENUMBER, '0, '0, '0, '0, 1'b0, mvdr_pkg::ST_OK, '0},
      '{1'b0, mvdr_pkg::CMD_RENUMBER, '0, '0, '0, '0, 1'b0, mvdr_pkg::ST_OK, '0},
      '{1'b0, mvdr_pkg::CMD_DELETE, 13'd1, '0, '0, '0, 1'b1, mvdr_pkg::ST_ORDER, '0},
      '{1'b0, mvdr_pkg::CMD_LOOKUP, 13'd2, '0, '0, '0, 1'b0, mvdr_pkg::ST_OK, '0},
      '{1'b0, mvdr_pkg::CMD_LOOKUP, 13'd4, '0, '0, '0, 1'b0, mvdr_pkg::ST_OK, '0},
      '{1'b0, mvdr_pkg::CMD_LOOKUP, '0, '0, '0, '0, 1'b1, mvdr_pkg::ST_RANGE, '0},
      // triangles: kept, dropped on a deleted corner, bad corners
      '{1'b0, mvdr_pkg::CMD_TRIANGLE, '0, 13'd1, 13'd3, 13'd4, 1'b0, mvdr_pkg::ST_OK, '0},
      '{1'b0, mvdr_pkg::CMD_TRIANGLE, '0, 13'd1, 13'd2, 13'd3, 1'b0, mvdr_pkg::ST_OK, '0},
      '{1'b0, mvdr_pkg::CMD_TRIANGLE, '0, '0, 13'd1, 13'd1, 1'b0, mvdr_pkg::ST_OK, '0},
      '{1'b0, mvdr_pkg::CMD_TRIANGLE, '0, 13'd8191, 13'd1, 13'd1, 1'b0, mvdr_pkg::ST_OK, '0},
      // count raised after renumber: new vertices read as removed
      '{1'b1, mvdr_pkg::CMD_START, 13'd4096, '0, '0, '0, 1'b0, mvdr_pkg::ST_OK, '0},
      '{1'b0, mvdr_pkg::CMD_LOOKUP, 13'd4096, '0, '0, '0, 1'b0, mvdr_pkg::ST_OK, '0},
      '{1'b0, mvdr_pkg::CMD_TRIANGLE, '0, 13'd1, 13'd3, 13'd4096, 1'b0, mvdr_pkg::ST_OK, '0},
      '{1'b0, mvdr_pkg::CMD_LOOKUP, 13'd8191, '0, '0, '0, 1'b0, mvdr_pkg::ST_OK, '0},
      // count lowered after renumber: corners above it are out of range
      '{1'b1, mvdr_pkg::CMD_START, 13'd1, '0, '0, '0, 1'b0, mvdr_pkg::ST_OK, '0},
      '{1'b0, mvdr_pkg::CMD_TRIANGLE, '0, 13'd1, 13'd1, 13'd1, 1'b0, mvdr_pkg::ST_OK, '0},
      '{1'b0, mvdr_pkg::CMD_TRIANGLE, '0, 13'd1, 13'd1, 13'd3, 1'b0, mvdr_pkg::ST_OK, '0},
      '{1'b0, CMD_SPARE_6, '0, '0, '0, '0, 1'b0, mvdr_pkg::ST_OK, '0}
   };

   function automatic int live_vertices();
      return (vertex_count_cfg > MAX_VERTS_DEF) ? MAX_VERTS_DEF : vertex_count_cfg;
   endfunction

   function automatic bit vertex_in_range(input logic [IDX_W-1:0] v);
      return (v >= 1) && (int'(v) <= live_vertices());
   endfunction

   // expected answer to one item; updates the mesh bookkeeping as the block does
   function automatic remap_result_type predict_remap(input logic [CMD_W-1:0] cmd,
                                                      input logic [IDX_W-1:0] vi,
                                                      input logic [IDX_W-1:0] ca,
                                                      input logic [IDX_W-1:0] cb,
                                                      input logic [IDX_W-1:0] cc);
      remap_result_type res;
      logic [IDX_W-1:0] ra, rb, rc;
      bit               show_vertices;
      int               live;
      res = '0;
      res.status = mvdr_pkg::ST_OK;
      show_vertices = 1'b0;
      live = live_vertices();
      case (cmd)
         mvdr_pkg::CMD_START: begin
            keep_flag = '{default: 1'b1};
            kept_vertex_total = 0;
            kept_tri_total = 0;
            remap_phase = mvdr_pkg::PH_MARK;
         end
         mvdr_pkg::CMD_DELETE: begin
            if (remap_phase != mvdr_pkg::PH_MARK) res.status = mvdr_pkg::ST_ORDER;
            else if (!vertex_in_range(vi)) res.status = mvdr_pkg::ST_RANGE;
            else keep_flag[vi - 1] = 1'b0;
         end
         mvdr_pkg::CMD_RENUMBER: begin
            show_vertices = 1'b1;
            if (remap_phase != mvdr_pkg::PH_MARK) begin
               res.status = mvdr_pkg::ST_ORDER;
            end else begin
               // dense 1-based numbering of the survivors, zero for everything else
               kept_vertex_total = 0;
               for (int i = 0; i < MAX_VERTS_DEF; i++) begin
                  if (i < live && keep_flag[i]) begin
                     kept_vertex_total++;
                     new_index[i] = IDX_W'(kept_vertex_total);
                  end else begin
                     new_index[i] = '0;
                  end
               end
               remap_phase = mvdr_pkg::PH_REMAP;
            end
         end
         mvdr_pkg::CMD_TRIANGLE: begin
            if (remap_phase != mvdr_pkg::PH_REMAP) begin
               res.status = mvdr_pkg::ST_ORDER;
            end else if (!vertex_in_range(ca) || !vertex_in_range(cb) ||
                         !vertex_in_range(cc)) begin
               res.status = mvdr_pkg::ST_RANGE;
            end else begin
               ra = new_index[ca - 1];
               rb = new_index[cb - 1];
               rc = new_index[cc - 1];
               if (ra != 0 && rb != 0 && rc != 0) begin
                  // id space full: survivor is refused and the count holds
                  if (kept_tri_total >= MAX_TRIS_DEF) begin
                     res.status = mvdr_pkg::ST_RANGE;
                  end else begin
                     kept_tri_total++;
                     res.kept = 1'b1;
                     res.new_id = OUT_W'(kept_tri_total);
                     res.new_a = ra;
                     res.new_b = rb;
                     res.new_c = rc;
                  end
               end
            end
         end
         mvdr_pkg::CMD_LOOKUP: begin
            if (remap_phase != mvdr_pkg::PH_REMAP) res.status = mvdr_pkg::ST_ORDER;
            else if (!vertex_in_range(vi)) res.status = mvdr_pkg::ST_RANGE;
            else begin
               res.new_id = OUT_W'(new_index[vi - 1]);
               res.kept = (new_index[vi - 1] != 0);
            end
         end
         default: res.status = mvdr_pkg::ST_ORDER;
      endcase
      res.total = show_vertices ? OUT_W'(kept_vertex_total) : OUT_W'(kept_tri_total);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   task automatic check_field(input string field, input logic [OUT_W-1:0] got,
                              input logic [OUT_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                   result_count, field, got, want));
   endtask

   // present one item and hold it until the block takes it
   task automatic issue_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] vi,
                             input logic [IDX_W-1:0] ca, input logic [IDX_W-1:0] cb,
                             input logic [IDX_W-1:0] cc, input bit typed,
                             input mvdr_pkg::status_type exp_status,
                             input logic [OUT_W-1:0] exp_total);
      remap_result_type res;
      req_command <= cmd;
      req_vertex_index <= vi;
      req_corner_a <= ca;
      req_corner_b <= cb;
      req_corner_c <= cc;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      res = predict_remap(cmd, vi, ca, cb, cc);
      if (typed) begin
         res = '0;
         res.status = exp_status;
         res.total = exp_total;
      end
      pending_results.push_back(res);
   endtask

   // random sender idling, now and then a full drain of the block
   task automatic sender_gap(input int pct);
      if ($urandom_range(0, 31) == 0) begin
         start <= 1'b0;
         do @(posedge clock); while (pending_results.size() != 0);
      end
      while ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // vertex count write and read back, only with the block idle
   task automatic write_vertex_count(input logic [IDX_W-1:0] value);
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0 || busy !== 1'b0);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= VERTEX_COUNT_ADDR;
      csr_pwdata <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      vertex_count_cfg = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== CSR_DW'(value))
         report_mismatch($sformatf("vertex_count read %0d, wrote %0d", csr_prdata, value));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // vertex index for a random item: mostly inside this round's window, some out of range
   function automatic logic [IDX_W-1:0] pick_vertex(input int base, input int span);
      int choice;
      choice = $urandom_range(0, 19);
      if (span == 0 || choice == 0) return IDX_W'($urandom());
      if (choice == 1) return '0;
      if (choice == 2) return IDX_W'(live_vertices() + 1);
      return IDX_W'(base + $urandom_range(0, span - 1));
   endfunction

   // item with any code and any field bits
   task automatic issue_noise();
      issue_item(CMD_W'($urandom_range(0, 7)), IDX_W'($urandom()), IDX_W'($urandom()),
                 IDX_W'($urandom()), IDX_W'($urandom()), 1'b0, mvdr_pkg::ST_OK, '0);
   endtask

   // result checker: every strobe is matched against the oldest expectation
   always @(posedge clock) begin : check_results
      remap_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         result_count++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d with nothing pending, status %0d",
                                      result_count, rsp_status));
         end else begin
            want = pending_results.pop_front();
            check_field("status", OUT_W'(rsp_status), OUT_W'(want.status));
            check_field("kept",   OUT_W'(rsp_kept),   OUT_W'(want.kept));
            check_field("new_id", rsp_new_id,         want.new_id);
            check_field("new_a",  OUT_W'(rsp_new_a),  OUT_W'(want.new_a));
            check_field("new_b",  OUT_W'(rsp_new_b),  OUT_W'(want.new_b));
            check_field("new_c",  OUT_W'(rsp_new_c),  OUT_W'(want.new_c));
            check_field("total",  rsp_total,          want.total);
         end
      end
   end

   // watchdog: too long without an accepted item or a result ends the run
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress in %0d cycles", WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int gap_pct [3];
      int round;
      int counted_items;
      int live;
      int span;
      int base;
      int choice;
      logic [IDX_W-1:0] vcount;
      gap_pct = '{0, 67, 12};
      round = 0;
      counted_items = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[r]) begin
         if (directed_rows[r].csr_write)
            write_vertex_count(directed_rows[r].vi);
         else
            issue_item(directed_rows[r].cmd, directed_rows[r].vi, directed_rows[r].ca,
                       directed_rows[r].cb, directed_rows[r].cc, directed_rows[r].typed,
                       directed_rows[r].exp_status, directed_rows[r].exp_total);
      end

      // random rounds: start, deletes, renumber, triangles and lookups, with some noise
      while (counted_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       vcount = 13'd0;
            1:       vcount = 13'd4096;
            2:       vcount = 13'd8191;
            3:       vcount = 13'd3;
            default: vcount = IDX_W'($urandom_range(4, 60));
         endcase
         write_vertex_count(vcount);
         live = live_vertices();
         span = (live > WINDOW) ? WINDOW : live;
         if (live <= WINDOW) base = 1;
         else if ($urandom_range(0, 3) == 0) base = live - WINDOW + 1;
         else base = $urandom_range(1, live - WINDOW + 1);

         sender_gap(gap_pct[round % 3]);
         issue_item(mvdr_pkg::CMD_START, '0, '0, '0, '0, 1'b0, mvdr_pkg::ST_OK, '0);
         repeat ($urandom_range(0, 10)) begin
            sender_gap(gap_pct[round % 3]);
            if ($urandom_range(0, 11) == 0) begin
               issue_noise();
            end else begin
               issue_item(mvdr_pkg::CMD_DELETE, pick_vertex(base, span), IDX_W'($urandom()),
                          IDX_W'($urandom()), IDX_W'($urandom()), 1'b0, mvdr_pkg::ST_OK, '0);
               counted_items++;
            end
         end
         sender_gap(gap_pct[round % 3]);
         issue_item(mvdr_pkg::CMD_RENUMBER, '0, '0, '0, '0, 1'b0, mvdr_pkg::ST_OK, '0);
         counted_items++;
         repeat ($urandom_range(10, 40)) begin
            sender_gap(gap_pct[round % 3]);
            choice = $urandom_range(0, 99);
            if (choice < 50) begin
               issue_item(mvdr_pkg::CMD_TRIANGLE, IDX_W'($urandom()), pick_vertex(base, span),
                          pick_vertex(base, span), pick_vertex(base, span), 1'b0,
                          mvdr_pkg::ST_OK, '0);
               counted_items++;
            end else if (choice < 88) begin
               issue_item(mvdr_pkg::CMD_LOOKUP, pick_vertex(base, span), IDX_W'($urandom()),
                          IDX_W'($urandom()), IDX_W'($urandom()), 1'b0, mvdr_pkg::ST_OK, '0);
               counted_items++;
            end else begin
               issue_noise();
            end
         end
         round++;
      end

      // drain, then watch a while for stray results
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/mvdr_pkg.sv
hdl/mvdr_ram.sv
hdl/mvdr_csr.sv
hdl/mesh_vertex_delete_remap.sv
tb/mesh_vertex_delete_remap_test.sv
